### rtl/echo_distance_median_filter_macros.svh
// ----------------------------------------------------------------------------
// echo distance median filter assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH
`define ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH

// assertion that is ignored while reset is held
`define EDMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds across reset
`define EDMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/edmf_pkg.sv
// ----------------------------------------------------------------------------
// edmf_pkg
// types and fixed constants of the echo distance median filter
// ----------------------------------------------------------------------------
package edmf_pkg;

  // field widths
  localparam int ECHO_W = 14;
  localparam int DIST_W = 16;

  // distance reported for a timed out reading
  localparam logic [DIST_W-1:0] DIST_TIMEOUT = 16'hFFFF;

  // timer limit: widths at or above this count as a timeout
  localparam logic [16:0] ECHO_LIMIT_US = 17'd10000;

  // width * 340 / 200 == (width * 17) / 10
  localparam int              SCALE_W   = 19;
  // reciprocal of 10 scaled by 2**22, exact for products below 699050
  localparam logic [SCALE_W-1:0] RECIP_10 = 19'd419431;
  localparam int              RECIP_SH  = 22;
  localparam int              PROD_W    = 2 * SCALE_W;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_MED_RD,
    ST_MED_OUT
  } edmf_state_t;

endpackage

### rtl/edmf_ram.sv
// ----------------------------------------------------------------------------
// edmf_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module edmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, returns old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/echo_distance_median_filter.sv
// ----------------------------------------------------------------------------
// echo_distance_median_filter
// a reading is accepted only in ST_IDLE and is then stored by an insertion
//   walk over the window ram: ST_SCAN moves one entry per cycle, and ST_PLACE
//   writes slot 0 or an empty window; no new reading is taken until it is stored;
//   the window-closing reading then passes ST_MED_RD and ST_MED_OUT, which
//   waits for out_tready while a result is still held, to register the median
// reset: window count and handshakes clear; the window ram is not cleared
// ----------------------------------------------------------------------------
module echo_distance_median_filter
  import edmf_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // input readings
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [13:0] echo_width_us, [15:14] zero
  input  logic        in_tuser,   // [0] timed_out
  // median distances
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] distance_mm
);

  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_LEN - 1);
  localparam logic [AW-1:0] MID_IDX  = AW'(WINDOW_LEN / 2);

  edmf_state_t       state_r, state_nxt;
  logic [AW-1:0]     fill_count_r, fill_count_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [DIST_W-1:0] new_r, new_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DIST_W-1:0] out_tdata_r, out_tdata_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DIST_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DIST_W-1:0] ram_rdata;

  logic [ECHO_W-1:0]  echo_w;
  logic [SCALE_W-1:0] scaled;
  logic [PROD_W-1:0]  prod;
  logic               is_timeout;
  logic [DIST_W-1:0]  dist_mm;
  logic               win_done;

  // width to distance: (w * 17) / 10 through a reciprocal multiply
  assign echo_w     = in_tdata[ECHO_W-1:0];
  assign scaled     = (SCALE_W'(echo_w) << 4) + SCALE_W'(echo_w);
  assign prod       = PROD_W'(scaled) * PROD_W'(RECIP_10);
  assign is_timeout = in_tuser || ({3'b000, echo_w} >= ECHO_LIMIT_US);
  assign dist_mm    = is_timeout ? DIST_TIMEOUT : prod[RECIP_SH +: DIST_W];

  // window ram, kept sorted ascending over entries 0..fill_count-1
  edmf_ram #(
    .WIDTH (DIST_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    new_r       <= new_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // insertion walk sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    pos_nxt        = pos_r;
    new_nxt        = new_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = new_r;
    ram_raddr      = pos_r;
    win_done       = 1'b0;

    // result register drains independently
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          new_nxt = dist_mm;
          if (fill_count_r == '0) begin
            pos_nxt   = '0;
            state_nxt = ST_PLACE;
          end else begin
            // start at the largest stored entry
            ram_raddr = fill_count_r - AW'(1);
            pos_nxt   = fill_count_r - AW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r + AW'(1);
        if (ram_rdata > new_r) begin
          // move entry up one slot and look one lower
          ram_wdata = ram_rdata;
          if (pos_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_raddr = pos_r - AW'(1);
            pos_nxt   = pos_r - AW'(1);
          end
        end else begin
          ram_wdata = new_r;
          win_done  = 1'b1;
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = new_r;
        win_done  = 1'b1;
      end
      ST_MED_RD: begin
        ram_raddr = MID_IDX;
        state_nxt = ST_MED_OUT;
      end
      ST_MED_OUT: begin
        ram_raddr = MID_IDX;
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = ram_rdata;
          fill_count_nxt = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // reading stored: close the window or count it
    if (win_done) begin
      if (fill_count_r == LAST_IDX) begin
        state_nxt = ST_MED_RD;
      end else begin
        fill_count_nxt = fill_count_r + AW'(1);
        state_nxt      = ST_IDLE;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `include "echo_distance_median_filter_macros.svh"

  `EDMF_ASSERT(a_fill_in_range, fill_count_r <= LAST_IDX, "fill count past window end")
  `EDMF_ASSERT(a_scan_below_fill, (state_r == ST_SCAN) |-> (pos_r < fill_count_r), "scan past fill")
  `EDMF_ASSERT(a_med_rd_then_out, (state_r == ST_MED_RD) |=> (state_r == ST_MED_OUT), "median read lost")
  `EDMF_ASSERT(a_out_from_median, $rose(out_tvalid_r) |-> $past(state_r == ST_MED_OUT), "result without median")
  `EDMF_ASSERT(a_window_restart, (state_r == ST_MED_OUT && state_nxt == ST_IDLE) |=> (fill_count_r == '0), "window not restarted")

endmodule
